// ----- rtl/fqja_pkg.sv -----
package fqja_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths of the channel ports
  localparam int ACTION_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int HANDLE_W   = 6;
  localparam int POSITION_W = 6;
  localparam int OCC_W      = 7;
  localparam int STATUS_W   = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_JUMP  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_POP,
    CELL_PUSH,
    CELL_JUMP
  } cell_op_t;

endpackage

// ----- rtl/fqja_ram.sv -----
module fqja_ram #(
  parameter int WIDTH = fqja_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = fqja_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/fqja_cell.sv -----
module fqja_cell #(
  parameter int DEPTH = fqja_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  fqja_pkg::cell_op_t               op,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic [$clog2(DEPTH)-1:0]         pos,
  input  logic [$clog2(DEPTH)-1:0]         target,
  input  logic [$clog2(DEPTH)-1:0]         match_key,
  input  logic [$clog2(DEPTH)-1:0]         load_key,
  input  logic [$clog2(DEPTH)-1:0]         prev_slot,
  input  logic [$clog2(DEPTH)-1:0]         next_slot,
  output logic [$clog2(DEPTH)-1:0]         slot,
  output logic                             match
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] slot_nxt;

  assign slot  = slot_r;
  // only slots below the fill count hold queued handles
  assign match = (slot_r == match_key) && (MY_CNT < count);

  always_comb begin
    slot_nxt = slot_r;
    case (op)
      fqja_pkg::CELL_POP: begin
        slot_nxt = next_slot;
      end
      fqja_pkg::CELL_PUSH: begin
        if (MY_CNT == count) begin
          slot_nxt = load_key;
        end
      end
      fqja_pkg::CELL_JUMP: begin
        if (MY_IDX == target) begin
          slot_nxt = load_key;
        end else if ((MY_IDX > target) && (MY_IDX <= pos)) begin
          slot_nxt = prev_slot;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ----- rtl/fifo_queue_with_jump_ahead.sv -----
// Each accepted word goes through a lookup state (handle compare across the cell row, lowest
// free handle search), then an apply state that shifts the cells and registers the result on
// the out_ ports. Apply waits while the output is stalled; a new word enters in idle or apply.
// Reset clears the fill count, the live-handle bits, the control state and the output valid.
// The order cells and the value RAM are not cleared; they are written before being read.
module fifo_queue_with_jump_ahead #(
  parameter int DEPTH       = fqja_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = fqja_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fqja_pkg::ACTION_W-1:0]   in_action,
  input  logic [fqja_pkg::VALUE_W-1:0]    in_value,
  input  logic [fqja_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [fqja_pkg::HANDLE_W-1:0]   in_jump_distance,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fqja_pkg::STATUS_W-1:0]   out_status,
  output logic [fqja_pkg::VALUE_W-1:0]    out_value,
  output logic [fqja_pkg::HANDLE_W-1:0]   out_handle,
  output logic [fqja_pkg::POSITION_W-1:0] out_position,
  output logic [fqja_pkg::OCC_W-1:0]      out_occupancy,
  output logic                            out_is_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = (IDX_W > fqja_pkg::HANDLE_W) ? IDX_W : fqja_pkg::HANDLE_W;

  // control
  fqja_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] live_r, live_nxt;
  logic             out_valid_r, out_valid_nxt;

  // captured command word
  fqja_pkg::action_t            act_r;
  logic [fqja_pkg::VALUE_W-1:0] val_r;
  logic [fqja_pkg::HANDLE_W-1:0] hdl_r;
  logic [fqja_pkg::HANDLE_W-1:0] dist_r;

  // lookup results
  fqja_pkg::status_t status_r, status_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  target_r, target_nxt;
  logic [IDX_W-1:0]  free_r, free_nxt;

  // output word
  logic [fqja_pkg::STATUS_W-1:0]   o_status_r, o_status_nxt;
  logic [fqja_pkg::VALUE_W-1:0]    o_value_r, o_value_nxt;
  logic [fqja_pkg::HANDLE_W-1:0]   o_handle_r, o_handle_nxt;
  logic [fqja_pkg::POSITION_W-1:0] o_pos_r, o_pos_nxt;
  logic [fqja_pkg::OCC_W-1:0]      o_occ_r, o_occ_nxt;
  logic                            o_empty_r, o_empty_nxt;

  logic              accept;
  logic              out_free;
  logic              apply_go;
  logic              ram_re;
  logic              ram_we;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic [IDX_W-1:0]  hdl_idx;
  logic [PW-1:0]     hdl_ext;
  logic              in_range;
  logic              found;
  logic [IDX_W-1:0]  pos_enc;
  logic [IDX_W-1:0]  free_enc;
  logic              any_free;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     dist_ext;

  fqja_pkg::cell_op_t cell_op;
  logic [IDX_W-1:0]   load_key;
  logic [IDX_W-1:0]   slot_w [DEPTH];
  logic [DEPTH-1:0]   match_w;

  assign out_free  = !out_valid_r || !out_stall;
  assign apply_go  = (state_r == fqja_pkg::S_APPLY) && out_free;
  assign in_stall  = !((state_r == fqja_pkg::S_IDLE) || apply_go);
  assign accept    = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = o_status_r;
  assign out_value     = o_value_r;
  assign out_handle    = o_handle_r;
  assign out_position  = o_pos_r;
  assign out_occupancy = o_occ_r;
  assign out_is_empty  = o_empty_r;

  // ---------------- cell row ----------------
  assign load_key = (act_r == fqja_pkg::ACT_PUSH) ? free_r : hdl_idx;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IDX_W-1:0] prev_s;
    logic [IDX_W-1:0] next_s;
    if (i == 0) begin : g_first
      assign prev_s = slot_w[i];
    end else begin : g_mid
      assign prev_s = slot_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_s = slot_w[i];
    end else begin : g_body
      assign next_s = slot_w[i+1];
    end

    fqja_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .count     (count_r),
      .pos       (pos_r),
      .target    (target_r),
      .match_key (hdl_idx),
      .load_key  (load_key),
      .prev_slot (prev_s),
      .next_slot (next_s),
      .slot      (slot_w[i]),
      .match     (match_w[i])
    );
  end

  // ---------------- value store ----------------
  assign ram_re = (state_r == fqja_pkg::S_LOOKUP);
  assign ram_we = apply_go && (act_r == fqja_pkg::ACT_PUSH) && (status_r == fqja_pkg::ST_OK);

  fqja_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (free_r),
    .wdata   (VALUE_WIDTH'(val_r)),
    .re      (ram_re),
    .raddr   (slot_w[0]),
    .rdata_r (ram_rdata)
  );

  // ---------------- lookup ----------------
  assign hdl_idx  = IDX_W'(hdl_r);
  assign hdl_ext  = PW'(hdl_r);
  assign in_range = {1'b0, hdl_ext} < (PW+1)'(DEPTH);
  assign found    = |match_w;
  assign any_free = ~&live_r;
  assign pos_ext  = PW'(pos_enc);
  assign dist_ext = PW'(dist_r);

  // one-hot match to binary
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_w[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  // lowest free handle
  always_comb begin
    free_enc = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_enc = IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt = fqja_pkg::ST_OK;
    case (act_r)
      fqja_pkg::ACT_PUSH: begin
        if ((count_r >= CNT_W'(DEPTH)) || !any_free) begin
          status_nxt = fqja_pkg::ST_FULL;
        end
      end
      fqja_pkg::ACT_POP: begin
        if (count_r == '0) begin
          status_nxt = fqja_pkg::ST_EMPTY;
        end
      end
      default: begin
        if (!in_range || !live_r[hdl_idx] || !found) begin
          status_nxt = fqja_pkg::ST_NOT_LIVE;
        end
      end
    endcase
    free_nxt   = free_enc;
    pos_nxt    = pos_enc;
    target_nxt = (dist_ext >= pos_ext) ? '0 : IDX_W'(pos_ext - dist_ext);
  end

  // ---------------- apply and FSM ----------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && out_stall;
    cell_op       = fqja_pkg::CELL_HOLD;
    o_status_nxt  = o_status_r;
    o_value_nxt   = o_value_r;
    o_handle_nxt  = o_handle_r;
    o_pos_nxt     = o_pos_r;
    o_occ_nxt     = o_occ_r;
    o_empty_nxt   = o_empty_r;

    case (state_r)
      fqja_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = fqja_pkg::S_LOOKUP;
        end
      end
      fqja_pkg::S_LOOKUP: begin
        state_nxt = fqja_pkg::S_APPLY;
      end
      fqja_pkg::S_APPLY: begin
        if (apply_go) begin
          o_value_nxt  = '0;
          o_handle_nxt = '0;
          o_pos_nxt    = '0;
          if (status_r == fqja_pkg::ST_OK) begin
            case (act_r)
              fqja_pkg::ACT_PUSH: begin
                cell_op           = fqja_pkg::CELL_PUSH;
                live_nxt[free_r]  = 1'b1;
                count_nxt         = count_r + 1'b1;
                o_handle_nxt      = fqja_pkg::HANDLE_W'(free_r);
              end
              fqja_pkg::ACT_POP: begin
                cell_op             = fqja_pkg::CELL_POP;
                live_nxt[slot_w[0]] = 1'b0;
                count_nxt           = count_r - 1'b1;
                o_value_nxt         = fqja_pkg::VALUE_W'(ram_rdata);
              end
              fqja_pkg::ACT_QUERY: begin
                o_pos_nxt = fqja_pkg::POSITION_W'(pos_r);
              end
              fqja_pkg::ACT_JUMP: begin
                cell_op = fqja_pkg::CELL_JUMP;
              end
              default: begin
                cell_op = fqja_pkg::CELL_HOLD;
              end
            endcase
          end
          o_status_nxt  = status_r;
          o_occ_nxt     = fqja_pkg::OCC_W'(count_nxt);
          o_empty_nxt   = (count_nxt == '0);
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? fqja_pkg::S_LOOKUP : fqja_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fqja_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqja_pkg::S_IDLE;
      count_r     <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= fqja_pkg::action_t'(in_action);
      val_r  <= in_value;
      hdl_r  <= in_handle;
      dist_r <= in_jump_distance;
    end
    if (state_r == fqja_pkg::S_LOOKUP) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      target_r <= target_nxt;
      free_r   <= free_nxt;
    end
    o_status_r <= o_status_nxt;
    o_value_r  <= o_value_nxt;
    o_handle_r <= o_handle_nxt;
    o_pos_r    <= o_pos_nxt;
    o_occ_r    <= o_occ_nxt;
    o_empty_r  <= o_empty_nxt;
  end

endmodule
